>>> rtl/core/tfg_pkg.sv
package tfg_pkg;

    // Coordinate and fixed point widths.
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 4;

    // Signed coordinate difference, product and squared-distance widths.
    localparam int DW    = COORD_BITS + 1;
    localparam int PRW   = 2 * DW;
    localparam int NW    = 2 * COORD_BITS + 1;
    localparam int RADW  = NW + 2 * FRAC_BITS;
    localparam int ROOTW = (RADW + 1) / 2;
    localparam int SQCW  = $clog2(ROOTW);

    // Field widths.
    localparam int TIMEW = 32;
    localparam int STRW  = 16;
    localparam int CNTW  = 3;
    localparam int EVW   = 3;
    localparam int AMTW  = 16;
    localparam int ACCW  = 32;
    localparam int DIVCW = $clog2(ACCW);

    // Configuration register widths.
    localparam int DELAYW = 10;
    localparam int THRW   = 13;
    localparam int TAPW   = 11;
    localparam int RDW    = 11;
    localparam int GAPW   = 8;
    localparam int DIVW   = RDW + 1;
    localparam int CFGIW  = 3;
    localparam int CFGDW  = 16;

    // Width used for spread threshold compares.
    localparam int THW = (ROOTW + 1 > THRW + FRAC_BITS + 1) ? ROOTW + 1
                                                            : THRW + FRAC_BITS + 1;

    // Configuration reset values.
    localparam logic [DELAYW-1:0] RST_DETECT = DELAYW'(100);
    localparam logic [THRW-1:0]   RST_ZOOM   = THRW'(100);
    localparam logic [THRW-1:0]   RST_MOVE   = THRW'(25);
    localparam logic [THRW-1:0]   RST_STABLE = THRW'(15);
    localparam logic [STRW-1:0]   RST_MINSTR = STRW'(1000);
    localparam logic [TAPW-1:0]   RST_TAP    = TAPW'(200);
    localparam logic [RDW-1:0]    RST_RDIST  = RDW'(8);
    localparam logic [GAPW-1:0]   RST_GAP    = GAPW'(16);

    localparam logic [CNTW-1:0] TWO_FINGERS = CNTW'(2);
    localparam logic            KIND_LIFT   = 1'b1;

    localparam logic signed [AMTW-1:0] AMT_MAX = 16'sh7FFF;
    localparam logic signed [AMTW-1:0] AMT_MIN = 16'sh8000;

    typedef enum logic [CFGIW-1:0] {
        CFG_DETECT_DELAY = 3'd0,
        CFG_ZOOM_TH      = 3'd1,
        CFG_MOVE_TH      = 3'd2,
        CFG_STABLE       = 3'd3,
        CFG_MIN_STR      = 3'd4,
        CFG_TAP_MAX      = 3'd5,
        CFG_REPORT_DIST  = 3'd6,
        CFG_SCROLL_GAP   = 3'd7
    } t_cfg_idx;

    typedef enum logic [EVW-1:0] {
        EV_PRESS    = 3'd0,
        EV_RELEASE  = 3'd1,
        EV_ZOOM_IN  = 3'd2,
        EV_ZOOM_OUT = 3'd3,
        EV_VWHEEL   = 3'd4,
        EV_HWHEEL   = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        G_NONE = 2'd0,
        G_ZOOM = 2'd1,
        G_VERT = 2'd2,
        G_HORZ = 2'd3
    } t_gesture;

    typedef enum logic [1:0] {
        OUT_PRESS   = 2'd0,
        OUT_RELEASE = 2'd1,
        OUT_ZOOM    = 2'd2,
        OUT_WHEEL   = 2'd3
    } t_out_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SUM,
        S_SQRT,
        S_DECIDE,
        S_SCROLL,
        S_DIV,
        S_WHEEL,
        S_PRESS,
        S_RELEASE,
        S_ZOOM
    } t_state;

    typedef struct packed {
        logic     load_in;
        logic     clr_session;
        logic     mul;
        logic     sum;
        logic     decide;
        logic     div_load;
        logic     out_load;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic is_lift;
        logic count_ok;
        logic hw_tap;
        logic strength_ok;
        logic tap_ok;
        logic sqrt_busy;
        logic zoom_go;
        logic scroll_go;
        logic div_need;
        logic div_busy;
        logic out_free;
    } t_status;

endpackage

>>> rtl/core/tfg_sqrt.sv
module tfg_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic [tfg_pkg::RADW-1:0]   i_rad,
    output logic                       o_busy,
    output logic [tfg_pkg::ROOTW-1:0]  o_root
);
    import tfg_pkg::*;

    logic [2*ROOTW-1:0] r_rad;
    logic [ROOTW+1:0]   r_rem;
    logic [ROOTW-1:0]   r_root;
    logic [SQCW-1:0]    r_cnt;
    logic               r_busy;
    logic [ROOTW+1:0]   w_sh;
    logic [ROOTW+1:0]   w_trial;
    logic               w_ge;

    // One root bit per cycle: bring down two radicand bits and try 4r+1.
    always_comb begin
        w_sh    = {r_rem[ROOTW-1:0], r_rad[2*ROOTW-1 -: 2]};
        w_trial = {r_root, 2'b01};
        w_ge    = (w_sh >= w_trial);
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_cnt  <= SQCW'(ROOTW - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Remainder and root registers.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rad  <= (2*ROOTW)'(i_rad);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= w_ge ? (w_sh - w_trial) : w_sh;
            r_root <= {r_root[ROOTW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

>>> rtl/core/tfg_div.sv
module tfg_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic [tfg_pkg::ACCW-1:0]  i_dividend,
    input  logic [tfg_pkg::DIVW-1:0]  i_divisor,
    output logic                      o_busy,
    output logic [tfg_pkg::ACCW-1:0]  o_quo,
    output logic [tfg_pkg::DIVW-1:0]  o_rem
);
    import tfg_pkg::*;

    logic [ACCW-1:0]  r_quo;
    logic [DIVW-1:0]  r_rem;
    logic [DIVW-1:0]  r_div;
    logic [DIVCW-1:0] r_cnt;
    logic             r_busy;
    logic [DIVW:0]    w_sh;
    logic             w_ge;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        w_sh = {r_rem, r_quo[ACCW-1]};
        w_ge = (w_sh >= {1'b0, r_div});
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_cnt  <= DIVCW'(ACCW - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Quotient and remainder registers.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? DIVW'(w_sh - {1'b0, r_div}) : DIVW'(w_sh);
            r_quo <= {r_quo[ACCW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

>>> rtl/core/tfg_datapath.sv
module tfg_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tfg_pkg::t_cmd                   i_cmd,
    output tfg_pkg::t_status                o_status,
    input  logic                            i_cfg_valid,
    input  logic [tfg_pkg::CFGIW-1:0]       i_cfg_index,
    input  logic [tfg_pkg::CFGDW-1:0]       i_cfg_data,
    input  logic                            i_kind,
    input  logic [tfg_pkg::TIMEW-1:0]       i_now_ms,
    input  logic [tfg_pkg::CNTW-1:0]        i_finger_count,
    input  logic                            i_hw_tap,
    input  logic [tfg_pkg::COORD_BITS-1:0]  i_first_x,
    input  logic [tfg_pkg::COORD_BITS-1:0]  i_first_y,
    input  logic [tfg_pkg::COORD_BITS-1:0]  i_second_x,
    input  logic [tfg_pkg::COORD_BITS-1:0]  i_second_y,
    input  logic [tfg_pkg::STRW-1:0]        i_first_strength,
    input  logic [tfg_pkg::STRW-1:0]        i_second_strength,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [tfg_pkg::EVW-1:0]         o_event_res,
    output logic signed [tfg_pkg::AMTW-1:0] o_amount,
    output logic                            o_last
);
    import tfg_pkg::*;

    function automatic logic signed [DW-1:0] f_diff(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    function automatic logic signed [ACCW-1:0] f_sat(input logic signed [ACCW:0] v);
        logic signed [ACCW-1:0] res;
        if (v[ACCW] != v[ACCW-1]) begin
            res = v[ACCW] ? {1'b1, {(ACCW-1){1'b0}}} : {1'b0, {(ACCW-1){1'b1}}};
        end else begin
            res = v[ACCW-1:0];
        end
        return res;
    endfunction

    // Configuration registers.
    logic [DELAYW-1:0] r_cfg_detect;
    logic [THRW-1:0]   r_cfg_zoom;
    logic [THRW-1:0]   r_cfg_move;
    logic [THRW-1:0]   r_cfg_stable;
    logic [STRW-1:0]   r_cfg_minstr;
    logic [TAPW-1:0]   r_cfg_tap;
    logic [RDW-1:0]    r_cfg_rdist;
    logic [GAPW-1:0]   r_cfg_gap;

    // Latched input word.
    logic                  r_kind;
    logic [TIMEW-1:0]      r_now;
    logic [CNTW-1:0]       r_count;
    logic                  r_tap;
    logic [COORD_BITS-1:0] r_c [4];
    logic [STRW-1:0]       r_s0;
    logic [STRW-1:0]       r_s1;

    // Session state.
    logic                  r_session_on;
    logic [TIMEW-1:0]      r_start_stamp;
    logic [TIMEW-1:0]      r_scroll_stamp;
    t_gesture              r_gesture;
    logic                  r_zoom_done;
    logic [COORD_BITS-1:0] r_start [4];
    logic [COORD_BITS-1:0] r_prev [4];
    logic [ROOTW-1:0]      r_start_spread;
    logic [ROOTW-1:0]      r_prev_spread;
    logic signed [ACCW-1:0] r_acc_x;
    logic signed [ACCW-1:0] r_acc_y;

    // Product and sum registers.
    logic signed [PRW-1:0] r_p [8];
    logic [2*THRW-1:0]     r_mt2;
    logic signed [PRW:0]   r_dot;
    logic                  r_still;
    t_event                r_zoom_ev;
    logic                  r_div_neg;

    // Output register.
    logic                  r_out_valid;
    t_event                r_out_ev;
    logic signed [AMTW-1:0] r_out_amt;
    logic                  r_out_last;

    // Unit interfaces.
    logic                  w_sqrt_busy;
    logic [ROOTW-1:0]      w_root;
    logic [RADW-1:0]       w_rad;
    logic                  w_div_busy;
    logic [ACCW-1:0]       w_quo;
    logic [DIVW-1:0]       w_rem;

    // Combinational helpers.
    logic [TIMEW-1:0]       w_el_start;
    logic [TIMEW-1:0]       w_el_scroll;
    logic                   w_detect_ok;
    logic                   w_gap_ok;
    logic                   w_strength_ok;
    logic signed [DW-1:0]   w_dx0, w_dy0, w_dx1, w_dy1, w_sdx, w_sdy;
    logic [NW-1:0]          w_n0, w_n1, w_nsp;
    logic signed [ROOTW:0]  w_ch, w_dl;
    logic [ROOTW:0]         w_ach, w_adl;
    logic [THW-1:0]         w_zt4, w_zt5, w_zsl4;
    logic signed [DW:0]     w_sx, w_sy;
    logic [DW:0]            w_asx, w_asy;
    logic [DW+2:0]          w_2sx, w_3sx, w_2sy, w_3sy;
    logic                   w_dot_neg, w_dot_pos;
    t_gesture               w_cls, w_g;
    logic                   w_zoom_emit;
    logic signed [DW:0]     w_mvx, w_mvy;
    logic signed [DW+2:0]   w_m3x, w_m3y;
    logic signed [ACCW:0]   w_sumx, w_sumy;
    logic [RDW-1:0]         w_rd1;
    logic [DIVW-1:0]        w_d;
    logic signed [ACCW-1:0] w_acc_sel;
    logic [ACCW-1:0]        w_mag;
    logic signed [ACCW-1:0] w_rem_s;
    logic signed [AMTW-1:0] w_wheel_amt;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_detect <= RST_DETECT;
            r_cfg_zoom   <= RST_ZOOM;
            r_cfg_move   <= RST_MOVE;
            r_cfg_stable <= RST_STABLE;
            r_cfg_minstr <= RST_MINSTR;
            r_cfg_tap    <= RST_TAP;
            r_cfg_rdist  <= RST_RDIST;
            r_cfg_gap    <= RST_GAP;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DETECT_DELAY: r_cfg_detect <= i_cfg_data[DELAYW-1:0];
                CFG_ZOOM_TH:      r_cfg_zoom   <= i_cfg_data[THRW-1:0];
                CFG_MOVE_TH:      r_cfg_move   <= i_cfg_data[THRW-1:0];
                CFG_STABLE:       r_cfg_stable <= i_cfg_data[THRW-1:0];
                CFG_MIN_STR:      r_cfg_minstr <= i_cfg_data[STRW-1:0];
                CFG_TAP_MAX:      r_cfg_tap    <= i_cfg_data[TAPW-1:0];
                CFG_REPORT_DIST:  r_cfg_rdist  <= i_cfg_data[RDW-1:0];
                CFG_SCROLL_GAP:   r_cfg_gap    <= i_cfg_data[GAPW-1:0];
                default:          r_cfg_gap    <= r_cfg_gap;
            endcase
        end
    end

    // Input word capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind  <= i_kind;
            r_now   <= i_now_ms;
            r_count <= i_finger_count;
            r_tap   <= i_hw_tap;
            r_c[0]  <= i_first_x;
            r_c[1]  <= i_first_y;
            r_c[2]  <= i_second_x;
            r_c[3]  <= i_second_y;
            r_s0    <= i_first_strength;
            r_s1    <= i_second_strength;
        end
    end

    // Elapsed times and report qualification.
    always_comb begin
        w_el_start    = r_now - r_start_stamp;
        w_el_scroll   = r_now - r_scroll_stamp;
        w_detect_ok   = (w_el_start >= TIMEW'(r_cfg_detect));
        w_gap_ok      = (w_el_scroll >= TIMEW'(r_cfg_gap));
        w_strength_ok = (r_s0 != '0) && (r_s1 != '0) &&
                        (r_s0 >= r_cfg_minstr) && (r_s1 >= r_cfg_minstr);
    end

    // Finger displacements from session start, and the finger spread vector.
    always_comb begin
        w_dx0 = f_diff(r_c[0], r_start[0]);
        w_dy0 = f_diff(r_c[1], r_start[1]);
        w_dx1 = f_diff(r_c[2], r_start[2]);
        w_dy1 = f_diff(r_c[3], r_start[3]);
        w_sdx = f_diff(r_c[2], r_c[0]);
        w_sdy = f_diff(r_c[3], r_c[1]);
    end

    // Products, one multiplier per term.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_p[0] <= w_dx0 * w_dx0;
            r_p[1] <= w_dy0 * w_dy0;
            r_p[2] <= w_dx1 * w_dx1;
            r_p[3] <= w_dy1 * w_dy1;
            r_p[4] <= w_dx0 * w_dx1;
            r_p[5] <= w_dy0 * w_dy1;
            r_p[6] <= w_sdx * w_sdx;
            r_p[7] <= w_sdy * w_sdy;
            r_mt2  <= r_cfg_move * r_cfg_move;
        end
    end

    // Sums of squares; a finger below the move threshold compares squares directly.
    always_comb begin
        w_n0  = r_p[0][NW-1:0] + r_p[1][NW-1:0];
        w_n1  = r_p[2][NW-1:0] + r_p[3][NW-1:0];
        w_nsp = r_p[6][NW-1:0] + r_p[7][NW-1:0];
        w_rad = RADW'(w_nsp) << (2 * FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_dot   <= r_p[4] + r_p[5];
            r_still <= (w_n0 < r_mt2) && (w_n1 < r_mt2);
        end
    end

    tfg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (i_cmd.sum),
        .i_rad   (w_rad),
        .o_busy  (w_sqrt_busy),
        .o_root  (w_root)
    );

    // Classification and zoom decision.
    always_comb begin
        w_ch   = $signed({1'b0, w_root}) - $signed({1'b0, r_start_spread});
        w_dl   = $signed({1'b0, w_root}) - $signed({1'b0, r_prev_spread});
        w_ach  = w_ch[ROOTW] ? $unsigned(-w_ch) : $unsigned(w_ch);
        w_adl  = w_dl[ROOTW] ? $unsigned(-w_dl) : $unsigned(w_dl);
        w_zt4  = THW'(r_cfg_zoom) << FRAC_BITS;
        w_zt5  = THW'(r_cfg_zoom) << (FRAC_BITS + 1);
        w_zsl4 = THW'(r_cfg_stable) << FRAC_BITS;
        w_sx   = w_dx0 + w_dx1;
        w_sy   = w_dy0 + w_dy1;
        w_asx  = w_sx[DW] ? $unsigned(-w_sx) : $unsigned(w_sx);
        w_asy  = w_sy[DW] ? $unsigned(-w_sy) : $unsigned(w_sy);
        w_2sx  = (DW+3)'(w_asx) << 1;
        w_2sy  = (DW+3)'(w_asy) << 1;
        w_3sx  = w_2sx + (DW+3)'(w_asx);
        w_3sy  = w_2sy + (DW+3)'(w_asy);
        w_dot_neg = r_dot[PRW];
        w_dot_pos = !r_dot[PRW] && (r_dot != '0);

        w_cls = G_NONE;
        if (!r_still) begin
            if ((THW'(w_ach) > w_zt4) && w_dot_neg) begin
                w_cls = G_ZOOM;
            end else if (w_dot_pos) begin
                if (w_2sy > w_3sx) begin
                    w_cls = G_VERT;
                end else if (w_2sx > w_3sy) begin
                    w_cls = G_HORZ;
                end
            end
        end
        w_g = (r_gesture == G_NONE) ? w_cls : r_gesture;
        w_zoom_emit = (THW'(w_adl) < w_zsl4) || (THW'(w_ach) > w_zt5);
    end

    // Scroll accumulation with saturation.
    always_comb begin
        w_mvx  = f_diff(r_c[0], r_prev[0]) + f_diff(r_c[2], r_prev[2]);
        w_mvy  = f_diff(r_c[1], r_prev[1]) + f_diff(r_c[3], r_prev[3]);
        w_m3x  = (w_mvx <<< 1) + w_mvx;
        w_m3y  = (w_mvy <<< 1) + w_mvy;
        w_sumx = r_acc_x + w_m3x;
        w_sumy = r_acc_y + w_m3y;
    end

    // Session state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session_on <= 1'b0;
            r_gesture    <= G_NONE;
            r_zoom_done  <= 1'b0;
            r_acc_x      <= '0;
            r_acc_y      <= '0;
        end else if (i_cmd.clr_session) begin
            r_session_on <= 1'b0;
            r_gesture    <= G_NONE;
            r_zoom_done  <= 1'b0;
            r_acc_x      <= '0;
            r_acc_y      <= '0;
        end else if (i_cmd.decide) begin
            if (!r_session_on) begin
                r_session_on <= 1'b1;
                r_gesture    <= G_NONE;
                r_zoom_done  <= 1'b0;
                r_acc_x      <= '0;
                r_acc_y      <= '0;
            end else if (w_detect_ok) begin
                r_gesture <= w_g;
                if (w_g == G_ZOOM && !r_zoom_done && w_zoom_emit) begin
                    r_zoom_done <= 1'b1;
                end
                if ((w_g == G_VERT || w_g == G_HORZ) && w_gap_ok) begin
                    r_acc_x <= f_sat(w_sumx);
                    r_acc_y <= f_sat(w_sumy);
                end
            end
        end else if (i_cmd.out_load && i_cmd.out_sel == OUT_WHEEL) begin
            if (r_gesture == G_HORZ) begin
                r_acc_x <= w_rem_s;
            end else begin
                r_acc_y <= w_rem_s;
            end
        end
    end

    // Session data registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            if (!r_session_on) begin
                r_start_stamp  <= r_now;
                r_scroll_stamp <= r_now;
                r_start_spread <= w_root;
                r_prev_spread  <= w_root;
                for (int i = 0; i < 4; i++) begin
                    r_start[i] <= r_c[i];
                    r_prev[i]  <= r_c[i];
                end
            end else if (w_detect_ok) begin
                if (w_g == G_ZOOM && !r_zoom_done) begin
                    r_prev_spread <= w_root;
                    r_zoom_ev     <= (!w_ch[ROOTW] && w_ch != '0) ? EV_ZOOM_IN : EV_ZOOM_OUT;
                end
                if ((w_g == G_VERT || w_g == G_HORZ) && w_gap_ok) begin
                    for (int i = 0; i < 4; i++) begin
                        r_prev[i] <= r_c[i];
                    end
                end
            end
        end else if (i_cmd.out_load && i_cmd.out_sel == OUT_WHEEL) begin
            r_scroll_stamp <= r_now;
        end
    end

    // Wheel step quotient: accumulator over twice the report distance.
    always_comb begin
        w_rd1     = (r_cfg_rdist == '0) ? RDW'(1) : r_cfg_rdist;
        w_d       = {w_rd1, 1'b0};
        w_acc_sel = (r_gesture == G_HORZ) ? r_acc_x : r_acc_y;
        w_mag     = w_acc_sel[ACCW-1] ? $unsigned(-w_acc_sel) : $unsigned(w_acc_sel);
        w_rem_s   = r_div_neg ? -$signed(ACCW'(w_rem)) : $signed(ACCW'(w_rem));
        if (r_div_neg) begin
            w_wheel_amt = (w_quo > ACCW'(AMT_MAX)) ? AMT_MAX : $signed(w_quo[AMTW-1:0]);
        end else begin
            w_wheel_amt = (w_quo > ACCW'($unsigned(AMT_MIN))) ? AMT_MIN
                                                               : -$signed(w_quo[AMTW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_div_neg <= w_acc_sel[ACCW-1];
        end
    end

    tfg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_cmd.div_load),
        .i_dividend (w_mag),
        .i_divisor  (w_d),
        .o_busy     (w_div_busy),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_amt  <= '0;
            r_out_last <= 1'b1;
            case (i_cmd.out_sel)
                OUT_PRESS: begin
                    r_out_ev   <= EV_PRESS;
                    r_out_last <= 1'b0;
                end
                OUT_RELEASE: r_out_ev <= EV_RELEASE;
                OUT_ZOOM:    r_out_ev <= r_zoom_ev;
                OUT_WHEEL: begin
                    r_out_ev  <= (r_gesture == G_HORZ) ? EV_HWHEEL : EV_VWHEEL;
                    r_out_amt <= w_wheel_amt;
                end
                default: r_out_ev <= EV_PRESS;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_event_res = r_out_ev;
    assign o_amount    = r_out_amt;
    assign o_last      = r_out_last;

    // Status to the controller.
    always_comb begin
        o_status.is_lift     = (r_kind == KIND_LIFT);
        o_status.count_ok    = (r_count == TWO_FINGERS);
        o_status.hw_tap      = r_tap;
        o_status.strength_ok = w_strength_ok;
        o_status.tap_ok      = r_session_on && (r_gesture == G_NONE) &&
                               (w_el_start < TIMEW'(r_cfg_tap));
        o_status.sqrt_busy   = w_sqrt_busy;
        o_status.zoom_go     = r_session_on && w_detect_ok && (w_g == G_ZOOM) &&
                               !r_zoom_done && w_zoom_emit;
        o_status.scroll_go   = r_session_on && w_detect_ok &&
                               (w_g == G_VERT || w_g == G_HORZ) && w_gap_ok;
        o_status.div_need    = (w_mag >= ACCW'(w_d));
        o_status.div_busy    = w_div_busy;
        o_status.out_free    = !r_out_valid || i_out_ready;
    end

`ifndef NO_ASSERTIONS
    a_zoom_done_needs_zoom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zoom_done |-> (r_gesture == G_ZOOM))
        else $error("zoom marked done outside a zoom gesture");

    a_gesture_needs_session: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gesture != G_NONE) |-> r_session_on)
        else $error("gesture locked without an open session");

    a_accum_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gesture == G_NONE) |-> (r_acc_x == '0 && r_acc_y == '0))
        else $error("scroll accumulator moved before a scroll gesture");
`endif

endmodule

>>> rtl/core/tfg_ctrl.sv
module tfg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tfg_pkg::t_status i_status,
    output tfg_pkg::t_cmd    o_cmd
);
    import tfg_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.out_sel = OUT_PRESS;
        o_in_ready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.is_lift) begin
                    o_cmd.clr_session = 1'b1;
                    n_state = i_status.tap_ok ? S_PRESS : S_IDLE;
                end else if (!i_status.count_ok) begin
                    n_state = S_IDLE;
                end else if (i_status.hw_tap) begin
                    n_state = S_PRESS;
                end else if (!i_status.strength_ok) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_SQRT;
            end
            S_SQRT: begin
                if (!i_status.sqrt_busy) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_status.zoom_go) begin
                    n_state = S_ZOOM;
                end else if (i_status.scroll_go) begin
                    n_state = S_SCROLL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCROLL: begin
                if (i_status.div_need) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_WHEEL;
                end
            end
            S_WHEEL: begin
                o_cmd.out_sel = OUT_WHEEL;
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_PRESS: begin
                o_cmd.out_sel = OUT_PRESS;
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_RELEASE;
                end
            end
            S_RELEASE: begin
                o_cmd.out_sel = OUT_RELEASE;
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_ZOOM: begin
                o_cmd.out_sel = OUT_ZOOM;
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("output word loaded over an untaken word");

    a_release_after_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RELEASE) |-> ($past(r_state) == S_PRESS || $past(r_state) == S_RELEASE))
        else $error("release reached without a press");

    a_decide_after_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.decide |-> !i_status.sqrt_busy)
        else $error("decision taken while the square root is still running");
`endif

endmodule

>>> rtl/core/two_finger_gesture_recognizer.sv
// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_ready     i_kind .. i_second_strength
// out       output     o_out_valid / i_out_ready   o_event_res, o_amount, o_last
// cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A report is decided in steps: accept, product, sum, the bit-serial square root of
// the finger spread, and the decision. A wheel step adds the scroll check, the
// bit-serial divider and the wheel output word, and any item can wait on output
// stalls; ignored reports and plain lifts end after the check, taps after two words.
// Reset is synchronous and active low; it loads the register defaults and closes
// the session. One item is in work at a time; a stalled output word holds the
// controller before its next load, and configuration words are always taken.
module two_finger_gesture_recognizer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_kind,
    input  logic [tfg_pkg::TIMEW-1:0]       i_now_ms,
    input  logic [tfg_pkg::CNTW-1:0]        i_finger_count,
    input  logic                            i_hw_tap,
    input  logic [tfg_pkg::COORD_BITS-1:0]  i_first_x,
    input  logic [tfg_pkg::COORD_BITS-1:0]  i_first_y,
    input  logic [tfg_pkg::COORD_BITS-1:0]  i_second_x,
    input  logic [tfg_pkg::COORD_BITS-1:0]  i_second_y,
    input  logic [tfg_pkg::STRW-1:0]        i_first_strength,
    input  logic [tfg_pkg::STRW-1:0]        i_second_strength,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tfg_pkg::EVW-1:0]         o_event_res,
    output logic signed [tfg_pkg::AMTW-1:0] o_amount,
    output logic                            o_last,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tfg_pkg::CFGIW-1:0]       i_cfg_index,
    input  logic [tfg_pkg::CFGDW-1:0]       i_cfg_data
);
    import tfg_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Configuration words are taken on every cycle.
    assign o_cfg_ready = 1'b1;

    tfg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tfg_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_kind            (i_kind),
        .i_now_ms          (i_now_ms),
        .i_finger_count    (i_finger_count),
        .i_hw_tap          (i_hw_tap),
        .i_first_x         (i_first_x),
        .i_first_y         (i_first_y),
        .i_second_x        (i_second_x),
        .i_second_y        (i_second_y),
        .i_first_strength  (i_first_strength),
        .i_second_strength (i_second_strength),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_event_res       (o_event_res),
        .o_amount          (o_amount),
        .o_last            (o_last)
    );

endmodule

>>> bench/two_finger_gesture_recognizer_tb.sv
module two_finger_gesture_recognizer_tb;
    import tfg_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    // Clock, reset and ports.
    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_kind;
    logic [31:0] i_now_ms;
    logic [2:0]  i_finger_count;
    logic        i_hw_tap;
    logic [11:0] i_first_x, i_first_y, i_second_x, i_second_y;
    logic [15:0] i_first_strength, i_second_strength;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_event_res;
    logic signed [15:0] o_amount;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    two_finger_gesture_recognizer dut (.*);

    // One expected output word.
    typedef struct packed {
        logic [2:0]         ev;
        logic signed [15:0] amt;
        logic               fin;
    } t_word;

    t_word       expected_words[$];
    int          error_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    logic [31:0] clock_ms;

    // Predictor copy of the registers.
    logic [9:0]  m_delay;
    logic [12:0] m_zoom_th, m_move_th, m_stable;
    logic [15:0] m_min_str;
    logic [10:0] m_tap_max, m_rdist;
    logic [7:0]  m_gap;

    // Predictor copy of the session.
    logic         m_on;
    logic [31:0]  m_start;
    t_gesture     m_gest;
    logic         m_locked;
    longint       m_sc[4];
    longint       m_pc[4];
    longint       m_sspread, m_pspread;
    logic         m_zdone;
    int           m_stable_cnt;
    longint       m_ax, m_ay;
    logic [31:0]  m_sstamp;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle counter with timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver readiness: random stalls, or a long hold-off when asked.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Compare each accepted output word with the oldest expectation.
    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word, event", o_event_res, -1);
            end else begin
                w = expected_words.pop_front();
                if (o_event_res !== w.ev) report_mismatch("event", o_event_res, w.ev);
                if (o_amount !== w.amt) report_mismatch("amount", o_amount, w.amt);
                if (o_last !== w.fin) report_mismatch("last", o_last, w.fin);
            end
        end
    end

    function automatic longint labs(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // Integer square root of v scaled by the fraction bits.
    function automatic longint scaled_spread(input longint dx, input longint dy);
        longint v, r, b;
        v = (dx * dx + dy * dy) << (2 * FRAC_BITS);
        r = 0;
        b = 64'sh1 << 60;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void push_word(input t_event ev, input longint amt, input logic fin);
        t_word w;
        if (amt > 32767) amt = 32767;
        if (amt < -32768) amt = -32768;
        w.ev  = ev;
        w.amt = 16'(amt);
        w.fin = fin;
        expected_words.push_back(w);
    endfunction

    function automatic void clear_model_session();
        m_on = 0; m_start = 0; m_gest = G_NONE; m_locked = 0;
        foreach (m_sc[i]) begin
            m_sc[i] = 0;
            m_pc[i] = 0;
        end
        m_sspread = 0; m_pspread = 0; m_zdone = 0; m_stable_cnt = 0;
        m_ax = 0; m_ay = 0; m_sstamp = 0;
    endfunction

    // Classify the motion since the session opened.
    function automatic t_gesture classify_motion(input longint c[4], input longint cur);
        longint dx0, dy0, dx1, dy1, mt, dot, sx, sy;
        dx0 = c[0] - m_sc[0]; dy0 = c[1] - m_sc[1];
        dx1 = c[2] - m_sc[2]; dy1 = c[3] - m_sc[3];
        mt  = longint'(m_move_th) << FRAC_BITS;
        if (scaled_spread(dx0, dy0) < mt && scaled_spread(dx1, dy1) < mt) return G_NONE;
        dot = dx0 * dx1 + dy0 * dy1;
        if (labs(cur - m_sspread) > (longint'(m_zoom_th) << FRAC_BITS) && dot < 0)
            return G_ZOOM;
        if (dot > 0) begin
            sx = labs(dx0 + dx1);
            sy = labs(dy0 + dy1);
            if (2 * sy > 3 * sx) return G_VERT;
            if (2 * sx > 3 * sy) return G_HORZ;
        end
        return G_NONE;
    endfunction

    // Predict the words one input item produces and update the session.
    function automatic void predict_gesture(input logic kind, input logic [31:0] now,
                                            input logic [2:0] cnt, input logic tap,
                                            input logic [11:0] fx, input logic [11:0] fy,
                                            input logic [11:0] sx, input logic [11:0] sy,
                                            input logic [15:0] s0, input logic [15:0] s1);
        longint c[4];
        longint cur, change, delta, d, q;
        logic [31:0] since;
        if (kind == KIND_LIFT) begin
            if (!m_on) return;
            since = now - m_start;
            if (!m_locked && since < m_tap_max && labs(m_ax) < 20 && labs(m_ay) < 20) begin
                push_word(EV_PRESS, 0, 1'b0);
                push_word(EV_RELEASE, 0, 1'b1);
            end
            clear_model_session();
            return;
        end
        if (cnt != TWO_FINGERS) return;
        if (tap) begin
            push_word(EV_PRESS, 0, 1'b0);
            push_word(EV_RELEASE, 0, 1'b1);
            return;
        end
        if (s0 == 0 || s1 == 0 || s0 < m_min_str || s1 < m_min_str) return;
        c[0] = fx; c[1] = fy; c[2] = sx; c[3] = sy;
        cur = scaled_spread(c[2] - c[0], c[3] - c[1]);
        if (!m_on) begin
            m_on = 1; m_start = now; m_gest = G_NONE; m_locked = 0;
            m_zdone = 0; m_stable_cnt = 0; m_sstamp = now;
            foreach (c[i]) begin
                m_sc[i] = c[i];
                m_pc[i] = c[i];
            end
            m_sspread = cur; m_pspread = cur; m_ax = 0; m_ay = 0;
            return;
        end
        since = now - m_start;
        if (since < m_delay) return;
        if (!m_locked && m_gest == G_NONE) begin
            m_gest = classify_motion(c, cur);
            if (m_gest != G_NONE) m_locked = 1;
        end
        if (m_gest == G_ZOOM) begin
            if (m_zdone) return;
            change = cur - m_sspread;
            delta  = cur - m_pspread;
            m_pspread = cur;
            if (labs(delta) < (longint'(m_stable) << FRAC_BITS)) begin
                if (m_stable_cnt < 255) m_stable_cnt++;
            end else begin
                m_stable_cnt = 0;
            end
            if (m_stable_cnt >= 1 || labs(change) > (longint'(m_zoom_th) << (FRAC_BITS + 1))) begin
                m_zdone = 1;
                push_word(change > 0 ? EV_ZOOM_IN : EV_ZOOM_OUT, 0, 1'b1);
            end
        end else if (m_gest == G_VERT || m_gest == G_HORZ) begin
            d = 2 * ((m_rdist == 0) ? 1 : longint'(m_rdist));
            since = now - m_sstamp;
            if (since < m_gap) return;
            m_ax = clamp32(m_ax + 3 * ((c[0] - m_pc[0]) + (c[2] - m_pc[2])));
            m_ay = clamp32(m_ay + 3 * ((c[1] - m_pc[1]) + (c[3] - m_pc[3])));
            if (m_gest == G_HORZ) begin
                if (labs(m_ax) >= d) begin
                    q = m_ax / d;
                    m_ax = m_ax - q * d;
                    push_word(EV_HWHEEL, -q, 1'b1);
                    m_sstamp = now;
                end
            end else if (labs(m_ay) >= d) begin
                q = m_ay / d;
                m_ay = m_ay - q * d;
                push_word(EV_VWHEEL, -q, 1'b1);
                m_sstamp = now;
            end
            foreach (c[i]) m_pc[i] = c[i];
        end
    endfunction

    // Send one input word and predict its results on acceptance.
    task automatic send_item(input logic kind, input logic [31:0] now, input logic [2:0] cnt,
                             input logic tap, input logic [11:0] fx, input logic [11:0] fy,
                             input logic [11:0] sx, input logic [11:0] sy,
                             input logic [15:0] s0, input logic [15:0] s1);
        do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        i_in_valid <= 1'b1;
        i_kind <= kind; i_now_ms <= now; i_finger_count <= cnt; i_hw_tap <= tap;
        i_first_x <= fx; i_first_y <= fy; i_second_x <= sx; i_second_y <= sy;
        i_first_strength <= s0; i_second_strength <= s1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_gesture(kind, now, cnt, tap, fx, fy, sx, sy, s0, s1);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Wait for every expected word, then let an item with no result finish.
    task automatic drain();
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DETECT_DELAY: m_delay   = val[9:0];
            CFG_ZOOM_TH:      m_zoom_th = val[12:0];
            CFG_MOVE_TH:      m_move_th = val[12:0];
            CFG_STABLE:       m_stable  = val[12:0];
            CFG_MIN_STR:      m_min_str = val;
            CFG_TAP_MAX:      m_tap_max = val[10:0];
            CFG_REPORT_DIST:  m_rdist   = val[10:0];
            default:          m_gap     = val[7:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_all_regs(input int dl, input int zt, input int mt, input int st,
                                input int ms, input int tm, input int rd, input int gp);
        drain();
        write_reg(CFG_DETECT_DELAY, 16'(dl));
        write_reg(CFG_ZOOM_TH, 16'(zt));
        write_reg(CFG_MOVE_TH, 16'(mt));
        write_reg(CFG_STABLE, 16'(st));
        write_reg(CFG_MIN_STR, 16'(ms));
        write_reg(CFG_TAP_MAX, 16'(tm));
        write_reg(CFG_REPORT_DIST, 16'(rd));
        write_reg(CFG_SCROLL_GAP, 16'(gp));
    endtask

    // Valid two-finger report at the running clock.
    task automatic touch(input int step, input int fx, input int fy, input int sx, input int sy);
        clock_ms = clock_ms + step;
        send_item(1'b0, clock_ms, TWO_FINGERS, 1'b0, 12'(fx), 12'(fy), 12'(sx), 12'(sy),
                  16'($urandom_range(65535, 40000)), 16'($urandom_range(65535, 40000)));
    endtask

    task automatic lift(input int step);
        clock_ms = clock_ms + step;
        send_item(KIND_LIFT, clock_ms, 3'($urandom), 1'($urandom), 12'($urandom),
                  12'($urandom), 12'($urandom), 12'($urandom), 16'($urandom),
                  16'($urandom));
    endtask

    // Directed: field extremes, taps, ignored reports, zoom and both scrolls.
    task automatic test_directed();
        send_item(1'b0, 32'hFFFF_FFFF, TWO_FINGERS, 1'b1, 12'hFFF, 12'hFFF, 0, 0, 0, 0);
        send_item(1'b0, 0, 3'd5, 1'b0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF);
        send_item(1'b0, 0, 3'd1, 1'b0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF);
        lift(0);
        send_item(1'b0, 5, TWO_FINGERS, 1'b0, 0, 0, 12'hFFF, 12'hFFF, 0, 16'hFFFF);
        send_item(1'b0, 5, TWO_FINGERS, 1'b0, 0, 0, 12'hFFF, 12'hFFF, 999, 16'hFFFF);
        // Quick lift gives a fallback tap.
        clock_ms = 32'hFFFF_FFF0;
        touch(0, 100, 100, 200, 200);
        lift(30);
        // Zoom out, wrapping time.
        touch(0, 1000, 1000, 3000, 3000);
        touch(150, 1400, 1400, 2600, 2600);
        touch(20, 1400, 1400, 2600, 2600);
        lift(10);
        // Zoom in.
        touch(0, 1500, 1500, 2500, 2500);
        touch(150, 1000, 1000, 3000, 3000);
        lift(5);
        // Vertical scroll both ways and horizontal scroll.
        touch(0, 1000, 1000, 1400, 1000);
        touch(120, 1000, 1100, 1400, 1100);
        touch(20, 1000, 1300, 1400, 1300);
        touch(20, 1000, 900, 1400, 900);
        lift(20);
        touch(0, 100, 2000, 100, 2400);
        touch(120, 300, 2000, 300, 2400);
        touch(20, 4095, 2000, 4095, 2400);
        touch(20, 0, 2000, 0, 2400);
        lift(20);
        // Hardware tap inside a session leaves it untouched.
        touch(0, 10, 10, 20, 20);
        send_item(1'b0, clock_ms, TWO_FINGERS, 1'b1, 0, 0, 0, 0, 0, 0);
        lift(1);
    endtask

    // One session with random gesture-shaped motion.
    task automatic random_session();
        int n, kindsel, step, fx, fy, sx, sy, vx, vy, wx, wy;
        n = $urandom_range(12, 2);
        kindsel = $urandom_range(3);
        fx = $urandom_range(3000, 500); fy = $urandom_range(3000, 500);
        sx = $urandom_range(3000, 500); sy = $urandom_range(3000, 500);
        vx = $urandom_range(60) - 30; vy = $urandom_range(60) - 30;
        case (kindsel)
            0: begin wx = vx; wy = vy; end
            1: begin wx = -vx; wy = -vy; end
            2: begin vx = $urandom_range(6) - 3; wx = vx; wy = vy * 4; vy = wy; end
            default: begin wx = $urandom_range(200) - 100; wy = $urandom_range(200) - 100; end
        endcase
        for (int k = 0; k < n; k++) begin
            step = ($urandom_range(9) == 0) ? $urandom : $urandom_range(60);
            if ($urandom_range(15) == 0)
                send_item(1'($urandom), clock_ms + step, 3'($urandom), 1'($urandom),
                          12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                          16'($urandom), 16'($urandom));
            else
                touch(step, fx, fy, sx, sy);
            fx = (fx + vx) & 12'hFFF; fy = (fy + vy) & 12'hFFF;
            sx = (sx + wx) & 12'hFFF; sy = (sy + wy) & 12'hFFF;
        end
        lift($urandom_range(300));
    endtask

    task automatic test_random(input int sessions);
        repeat (sessions) random_session();
    endtask

    // Long receiver hold-off while items keep coming, then a sender pause.
    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_cycles = 600;
        repeat (6) send_item(1'b0, clock_ms, TWO_FINGERS, 1'b1, 0, 0, 0, 0, 1, 1);
        drain();
    endtask

    initial begin
        error_count = 0; cycle_count = 0; hold_cycles = 0;
        send_idle_pct = 0; recv_stall_pct = 0; clock_ms = 0;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_out_ready = 1'b0;
        i_kind = 0; i_now_ms = 0; i_finger_count = 0; i_hw_tap = 0;
        i_first_x = 0; i_first_y = 0; i_second_x = 0; i_second_y = 0;
        i_first_strength = 0; i_second_strength = 0;
        i_cfg_valid = 0; i_cfg_index = CFG_DETECT_DELAY; i_cfg_data = 0;
        m_delay = RST_DETECT; m_zoom_th = RST_ZOOM; m_move_th = RST_MOVE;
        m_stable = RST_STABLE; m_min_str = RST_MINSTR; m_tap_max = RST_TAP;
        m_rdist = RST_RDIST; m_gap = RST_GAP;
        clear_model_session();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_backpressure();
        set_all_regs(0, 0, 0, 0, 0, 0, 0, 0);
        test_directed();
        test_random(15);
        set_all_regs(1023, 8191, 8191, 8191, 65535, 2047, 2047, 255);
        test_random(10);
        set_all_regs(100, 100, 25, 15, 1000, 200, 8, 16);
        test_random(40);
        send_idle_pct = 57;
        test_random(30);
        send_idle_pct = 0; recv_stall_pct = 57;
        set_all_regs(20, 30, 5, 3, 500, 2000, 1, 0);
        test_random(30);
        send_idle_pct = 20; recv_stall_pct = 20;
        set_all_regs(60, 200, 10, 40, 100, 500, 1024, 5);
        test_random(40);
        test_backpressure();
        drain();

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
